// File: rtl/core/unlt_pkg.sv
`default_nettype none
package unlt_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;
    localparam int PROD_W    = 2 * DIFF_W;
    localparam int VEC_W     = PROD_W + 1;
    localparam int MAG_BITS  = 31;
    localparam int LEN_W     = 7;
    localparam int SHIFT_W   = 6;
    localparam int SQ_W      = 2 * MAG_BITS;
    localparam int SUM_W     = 64;
    localparam int ROOT_W    = SUM_W / 2;
    localparam int NORM_FRAC = 30;
    localparam int NUM_W     = MAG_BITS + NORM_FRAC + 1;
    localparam int Q_W       = MAG_BITS;
    localparam int OUT_W     = 32;
    localparam int SQ_STEPS  = ROOT_W;
    localparam int DIV_STEPS = Q_W;

    localparam logic [1:0] LINE_POINTS = 2'd2;
    localparam logic [1:0] TRI_POINTS  = 2'd3;

    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_LINE   = 2'd1,
        KIND_TRI    = 2'd2,
        KIND_OTHER  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_UNSUP = 2'd1,
        ST_COUNT = 2'd2,
        ST_ZERO  = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]                  element_kind;
        logic [1:0]                  point_count;
        logic signed [COORD_W-1:0]   point_a_x;
        logic signed [COORD_W-1:0]   point_a_y;
        logic signed [COORD_W-1:0]   point_a_z;
        logic signed [COORD_W-1:0]   point_b_x;
        logic signed [COORD_W-1:0]   point_b_y;
        logic signed [COORD_W-1:0]   point_b_z;
        logic signed [COORD_W-1:0]   point_c_x;
        logic signed [COORD_W-1:0]   point_c_y;
        logic signed [COORD_W-1:0]   point_c_z;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] normal_x;
        logic signed [OUT_W-1:0] normal_y;
        logic signed [OUT_W-1:0] normal_z;
        logic [1:0]              status;
    } t_out_item;

    // travels beside the norm computation
    typedef struct packed {
        t_status                     status;
        logic                        calc;
        logic [2:0]                  neg;
        logic [2:0][MAG_BITS-1:0]    mag;
    } t_side;

    typedef struct packed {
        logic [SUM_W-1:0]  rad;
        logic [ROOT_W+1:0] rem;
        logic [ROOT_W-1:0] root;
    } t_sq;

    typedef struct packed {
        logic [ROOT_W-1:0] rem;
        logic [Q_W-1:0]    ql;
    } t_dv;

    function automatic logic [LEN_W-1:0] bit_len(input logic [VEC_W-1:0] v);
        logic [LEN_W-1:0] n;
        n = '0;
        for (int i = 0; i < VEC_W; i++) begin
            if (v[i]) begin
                n = LEN_W'(i + 1);
            end
        end
        return n;
    endfunction

    // one root bit per call
    function automatic t_sq sqrt_step(input t_sq a);
        t_sq               r;
        logic [ROOT_W+3:0] r2;
        logic [ROOT_W+3:0] trial;
        r2    = {a.rem, a.rad[SUM_W-1 -: 2]};
        trial = {2'b00, a.root, 2'b01};
        r.rad = {a.rad[SUM_W-3:0], 2'b00};
        if (r2 >= trial) begin
            r.rem  = (ROOT_W+2)'(r2 - trial);
            r.root = {a.root[ROOT_W-2:0], 1'b1};
        end else begin
            r.rem  = (ROOT_W+2)'(r2);
            r.root = {a.root[ROOT_W-2:0], 1'b0};
        end
        return r;
    endfunction

    // one quotient bit per call, restoring
    function automatic t_dv div_step(input t_dv a, input logic [ROOT_W-1:0] d);
        t_dv             r;
        logic [ROOT_W:0] r2;
        r2 = {a.rem, a.ql[Q_W-1]};
        if (r2 >= {1'b0, d}) begin
            r.rem = ROOT_W'(r2 - {1'b0, d});
            r.ql  = {a.ql[Q_W-2:0], 1'b1};
        end else begin
            r.rem = ROOT_W'(r2);
            r.ql  = {a.ql[Q_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/unlt_stream_if.sv
`default_nettype none
interface unlt_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/core/unit_normal_line_triangle_top.sv
// Unit normal of one mesh element per transfer.
// Input channel i_in carries the element kind, its point count and three
// points in signed Q16.16; output channel o_out carries the normal in signed
// Q2.30 and a status (ok, unsupported kind, wrong point count, zero length).
// Both channels transfer when valid and ready are high at a rising edge.
// The path from input transfer to output valid has 8 front stages
// (differences, products, cross product, magnitudes, shift search, scaling,
// squares, sum), 32 square root stages of one root bit each, one numerator
// stage, 31 divider stages of one quotient bit each and the output register.
// Throughput is one element per cycle while the receiver keeps o_out.ready
// high; the bit-serial root and divide pipelines set the latency, not the rate.
// When the receiver holds ready low with a result waiting, the whole
// pipeline freezes and i_in.ready drops; nothing is lost or repeated and
// bubbles in flight are kept. Reset (synchronous, active low) clears every
// valid bit; data registers keep whatever they hold.
`default_nettype none
module unit_normal_line_triangle_top (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    unlt_stream_if.sink   i_in,
    unlt_stream_if.source o_out
);
    import unlt_pkg::*;

    logic              w_en;
    logic              w_f_valid;
    logic [SUM_W-1:0]  w_f_sum;
    t_side             w_f_side;
    logic              w_s_valid;
    logic [ROOT_W-1:0] w_s_norm;
    t_side             w_s_side;
    logic              w_d_valid;
    t_out_item         w_d_item;

    // advance whenever the output register is empty or being drained
    assign w_en       = !w_d_valid || o_out.ready;
    assign i_in.ready = w_en;

    unlt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_item  (i_in.data),
        .o_valid (w_f_valid),
        .o_sum   (w_f_sum),
        .o_side  (w_f_side)
    );

    unlt_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_sum   (w_f_sum),
        .i_side  (w_f_side),
        .o_valid (w_s_valid),
        .o_norm  (w_s_norm),
        .o_side  (w_s_side)
    );

    unlt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_s_valid),
        .i_norm  (w_s_norm),
        .i_side  (w_s_side),
        .o_valid (w_d_valid),
        .o_item  (w_d_item)
    );

    assign o_out.valid = w_d_valid;
    assign o_out.data  = w_d_item;
endmodule
`default_nettype wire

// File: rtl/core/unlt_front.sv
`default_nettype none
module unlt_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_en,
    input  wire logic                           i_valid,
    input  wire unlt_pkg::t_in_item             i_item,
    output logic                                o_valid,
    output logic [unlt_pkg::SUM_W-1:0]          o_sum,
    output unlt_pkg::t_side                     o_side
);
    import unlt_pkg::*;

    // stage 1: differences and decode
    logic                     r1_valid, r1_calc, r1_tri;
    t_status                  r1_status;
    logic signed [DIFF_W-1:0] r1_ux, r1_uy, r1_uz, r1_vx, r1_vy, r1_vz;
    t_status                  n1_status;
    logic                     n1_calc;

    always_comb begin
        n1_status = ST_OK;
        n1_calc   = 1'b0;
        case (t_kind'(i_item.element_kind))
            KIND_OTHER: n1_status = ST_UNSUP;
            KIND_LINE: begin
                if (i_item.point_count != LINE_POINTS) n1_status = ST_COUNT;
                else n1_calc = 1'b1;
            end
            KIND_TRI: begin
                if (i_item.point_count != TRI_POINTS) n1_status = ST_COUNT;
                else n1_calc = 1'b1;
            end
            default: n1_calc = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
        end
        if (i_en) begin
            r1_status <= n1_status;
            r1_calc   <= n1_calc;
            r1_tri    <= (t_kind'(i_item.element_kind) == KIND_TRI);
            r1_ux <= DIFF_W'(i_item.point_b_x) - DIFF_W'(i_item.point_a_x);
            r1_uy <= DIFF_W'(i_item.point_b_y) - DIFF_W'(i_item.point_a_y);
            r1_uz <= DIFF_W'(i_item.point_b_z) - DIFF_W'(i_item.point_a_z);
            r1_vx <= DIFF_W'(i_item.point_c_x) - DIFF_W'(i_item.point_a_x);
            r1_vy <= DIFF_W'(i_item.point_c_y) - DIFF_W'(i_item.point_a_y);
            r1_vz <= DIFF_W'(i_item.point_c_z) - DIFF_W'(i_item.point_a_z);
        end
    end

    // stage 2: cross product terms
    logic                     r2_valid, r2_calc, r2_tri;
    t_status                  r2_status;
    logic signed [DIFF_W-1:0] r2_ux, r2_uy, r2_uz;
    logic signed [PROD_W-1:0] r2_p0, r2_p1, r2_p2, r2_p3, r2_p4, r2_p5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (i_en) begin
            r2_valid <= r1_valid;
        end
        if (i_en) begin
            r2_status <= r1_status;
            r2_calc   <= r1_calc;
            r2_tri    <= r1_tri;
            r2_ux <= r1_ux;
            r2_uy <= r1_uy;
            r2_uz <= r1_uz;
            r2_p0 <= r1_uy * r1_vz;
            r2_p1 <= r1_uz * r1_vy;
            r2_p2 <= r1_uz * r1_vx;
            r2_p3 <= r1_ux * r1_vz;
            r2_p4 <= r1_ux * r1_vy;
            r2_p5 <= r1_uy * r1_vx;
        end
    end

    // stage 3: raw vector; a line uses (b-a) turned to (uy, -ux, -uz)
    logic                    r3_valid, r3_calc;
    t_status                 r3_status;
    logic signed [VEC_W-1:0] r3_v0, r3_v1, r3_v2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r3_valid <= r2_valid;
        end
        if (i_en) begin
            r3_status <= r2_status;
            r3_calc   <= r2_calc;
            if (r2_tri) begin
                r3_v0 <= VEC_W'(r2_p0) - VEC_W'(r2_p1);
                r3_v1 <= VEC_W'(r2_p2) - VEC_W'(r2_p3);
                r3_v2 <= VEC_W'(r2_p4) - VEC_W'(r2_p5);
            end else begin
                r3_v0 <= VEC_W'(r2_uy);
                r3_v1 <= -VEC_W'(r2_ux);
                r3_v2 <= -VEC_W'(r2_uz);
            end
        end
    end

    // stage 4: magnitudes
    logic             r4_valid, r4_calc;
    t_status          r4_status;
    logic [2:0]       r4_neg;
    logic [VEC_W-1:0] r4_m0, r4_m1, r4_m2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (i_en) begin
            r4_valid <= r3_valid;
        end
        if (i_en) begin
            r4_status <= r3_status;
            r4_calc   <= r3_calc;
            r4_neg    <= {r3_v2[VEC_W-1], r3_v1[VEC_W-1], r3_v0[VEC_W-1]};
            r4_m0 <= r3_v0[VEC_W-1] ? VEC_W'(-r3_v0) : VEC_W'(r3_v0);
            r4_m1 <= r3_v1[VEC_W-1] ? VEC_W'(-r3_v1) : VEC_W'(r3_v1);
            r4_m2 <= r3_v2[VEC_W-1] ? VEC_W'(-r3_v2) : VEC_W'(r3_v2);
        end
    end

    // stage 5: zero-length check and shift amount that brings all magnitudes below 2^31
    logic               r5_valid, r5_calc;
    t_status            r5_status;
    logic [2:0]         r5_neg;
    logic [VEC_W-1:0]   r5_m0, r5_m1, r5_m2;
    logic [SHIFT_W-1:0] r5_shift;
    logic [LEN_W-1:0]   n5_len;
    logic [VEC_W-1:0]   n5_or;

    assign n5_or  = r4_m0 | r4_m1 | r4_m2;
    assign n5_len = bit_len(n5_or);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (i_en) begin
            r5_valid <= r4_valid;
        end
        if (i_en) begin
            r5_calc <= r4_calc;
            r5_neg  <= r4_neg;
            r5_m0   <= r4_m0;
            r5_m1   <= r4_m1;
            r5_m2   <= r4_m2;
            if (r4_calc && r4_status == ST_OK && n5_or == '0) begin
                r5_status <= ST_ZERO;
            end else begin
                r5_status <= r4_status;
            end
            if (n5_len > LEN_W'(MAG_BITS)) begin
                r5_shift <= SHIFT_W'(n5_len - LEN_W'(MAG_BITS));
            end else begin
                r5_shift <= '0;
            end
        end
    end

    // stage 6: scale down
    logic    r6_valid;
    t_side   r6_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_valid <= 1'b0;
        end else if (i_en) begin
            r6_valid <= r5_valid;
        end
        if (i_en) begin
            r6_side.status <= r5_status;
            r6_side.calc   <= r5_calc;
            r6_side.neg    <= r5_neg;
            r6_side.mag[0] <= MAG_BITS'(r5_m0 >> r5_shift);
            r6_side.mag[1] <= MAG_BITS'(r5_m1 >> r5_shift);
            r6_side.mag[2] <= MAG_BITS'(r5_m2 >> r5_shift);
        end
    end

    // stage 7: squares
    logic            r7_valid;
    t_side           r7_side;
    logic [SQ_W-1:0] r7_sq0, r7_sq1, r7_sq2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_valid <= 1'b0;
        end else if (i_en) begin
            r7_valid <= r6_valid;
        end
        if (i_en) begin
            r7_side <= r6_side;
            r7_sq0  <= SQ_W'(r6_side.mag[0]) * SQ_W'(r6_side.mag[0]);
            r7_sq1  <= SQ_W'(r6_side.mag[1]) * SQ_W'(r6_side.mag[1]);
            r7_sq2  <= SQ_W'(r6_side.mag[2]) * SQ_W'(r6_side.mag[2]);
        end
    end

    // stage 8: sum of squares
    logic             r8_valid;
    t_side            r8_side;
    logic [SUM_W-1:0] r8_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_valid <= 1'b0;
        end else if (i_en) begin
            r8_valid <= r7_valid;
        end
        if (i_en) begin
            r8_side <= r7_side;
            r8_sum  <= SUM_W'(r7_sq0) + SUM_W'(r7_sq1) + SUM_W'(r7_sq2);
        end
    end

    assign o_valid = r8_valid;
    assign o_sum   = r8_sum;
    assign o_side  = r8_side;
endmodule
`default_nettype wire

// File: rtl/core/unlt_sqrt.sv
`default_nettype none
module unlt_sqrt (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [unlt_pkg::SUM_W-1:0]    i_sum,
    input  wire unlt_pkg::t_side               i_side,
    output logic                               o_valid,
    output logic [unlt_pkg::ROOT_W-1:0]        o_norm,
    output unlt_pkg::t_side                    o_side
);
    import unlt_pkg::*;

    logic  r_valid [SQ_STEPS];
    t_sq   r_sq    [SQ_STEPS];
    t_side r_side  [SQ_STEPS];
    t_sq   w_first;

    assign w_first = '{rad: i_sum, rem: '0, root: '0};

    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= (g == 0) ? i_valid : r_valid[(g == 0) ? 0 : g - 1];
            end
            if (i_en) begin
                if (g == 0) begin
                    r_sq[g]   <= sqrt_step(w_first);
                    r_side[g] <= i_side;
                end else begin
                    r_sq[g]   <= sqrt_step(r_sq[(g == 0) ? 0 : g - 1]);
                    r_side[g] <= r_side[(g == 0) ? 0 : g - 1];
                end
            end
        end
    end

    assign o_valid = r_valid[SQ_STEPS-1];
    assign o_norm  = r_sq[SQ_STEPS-1].root;
    assign o_side  = r_side[SQ_STEPS-1];
endmodule
`default_nettype wire

// File: rtl/core/unlt_div.sv
`default_nettype none
module unlt_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_en,
    input  wire logic                          i_valid,
    input  wire logic [unlt_pkg::ROOT_W-1:0]   i_norm,
    input  wire unlt_pkg::t_side               i_side,
    output logic                               o_valid,
    output unlt_pkg::t_out_item                o_item
);
    import unlt_pkg::*;

    localparam int NST = DIV_STEPS + 1;

    // stage 0 forms the rounded numerator, the rest make one quotient bit each
    logic                   r_valid [NST];
    t_status                r_stat  [NST];
    logic                   r_calc  [NST];
    logic [2:0]             r_neg   [NST];
    logic [ROOT_W-1:0]      r_norm  [NST];
    t_dv [2:0]              r_lane  [NST];
    t_dv [2:0]              w_init;
    logic [NUM_W-1:0]       w_num   [3];

    for (genvar l = 0; l < 3; l++) begin : g_prep
        assign w_num[l] = NUM_W'({i_side.mag[l], NORM_FRAC'(0)}) + NUM_W'(i_norm >> 1);
        assign w_init[l].rem = ROOT_W'(w_num[l][NUM_W-1:Q_W]);
        assign w_init[l].ql  = w_num[l][Q_W-1:0];
    end

    for (genvar g = 0; g < NST; g++) begin : g_step
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[g] <= 1'b0;
            end else if (i_en) begin
                r_valid[g] <= (g == 0) ? i_valid : r_valid[(g == 0) ? 0 : g - 1];
            end
            if (i_en) begin
                if (g == 0) begin
                    r_stat[g] <= i_side.status;
                    r_calc[g] <= i_side.calc;
                    r_neg[g]  <= i_side.neg;
                    r_norm[g] <= i_norm;
                    r_lane[g] <= w_init;
                end else begin
                    r_stat[g] <= r_stat[(g == 0) ? 0 : g - 1];
                    r_calc[g] <= r_calc[(g == 0) ? 0 : g - 1];
                    r_neg[g]  <= r_neg[(g == 0) ? 0 : g - 1];
                    r_norm[g] <= r_norm[(g == 0) ? 0 : g - 1];
                    for (int l = 0; l < 3; l++) begin
                        r_lane[g][l] <= div_step(r_lane[(g == 0) ? 0 : g - 1][l],
                                                 r_norm[(g == 0) ? 0 : g - 1]);
                    end
                end
            end
        end
    end

    // output register: sign and forcing to zero
    logic                 r_out_valid;
    t_out_item            r_out;
    logic                 w_good;
    logic [OUT_W-1:0]     w_q   [3];
    logic [OUT_W-1:0]     w_val [3];

    assign w_good = (r_stat[NST-1] == ST_OK) && r_calc[NST-1];

    for (genvar l = 0; l < 3; l++) begin : g_sign
        assign w_q[l]   = OUT_W'(r_lane[NST-1][l].ql);
        assign w_val[l] = !w_good ? '0 : (r_neg[NST-1][l] ? -w_q[l] : w_q[l]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_en) begin
            r_out_valid <= r_valid[NST-1];
        end
        if (i_en) begin
            r_out.normal_x <= w_val[0];
            r_out.normal_y <= w_val[1];
            r_out.normal_z <= w_val[2];
            r_out.status   <= (r_calc[NST-1] || r_stat[NST-1] != ST_OK)
                              ? r_stat[NST-1] : ST_OK;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out;
endmodule
`default_nettype wire
